// File: sv/stcl_pkg.sv
// Shared types and constants for the sorted topic count list block.
// No dependencies; every other file but stcl_row_mem.sv uses it.
`default_nettype none

package stcl_pkg;

    // Fixed widths of the request and result fields
    localparam int FUNC_W     = 2;
    localparam int WORD_W     = 10;
    localparam int TOPIC_W    = 5;
    localparam int SLOT_W     = 5;
    localparam int CNT_OUT_W  = 16;
    localparam int STATUS_W   = 2;

    // Configuration port
    localparam int                TIU_W     = 6;
    localparam logic [TIU_W-1:0]  TIU_RESET = 6'd32;
    localparam int                PADDR_W   = 3;
    localparam int                PDATA_W   = 32;
    localparam logic              REG_TIU   = 1'b0;   // word index of topics_in_use

    typedef enum logic [FUNC_W-1:0] {
        FN_INC  = 2'd0,
        FN_DEC  = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_ABSENT = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_SAT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count_out;
        logic [TOPIC_W-1:0]   topic_out;
        logic [SLOT_W-1:0]    slot_out;
        t_status              status;
    } t_result;

    // Outcome of the row scan, handed to the update stage
    typedef struct packed {
        logic found;   // topic present in the live part of the list
        logic full;    // no live-end slot: every slot is live and none matches
        logic sat;     // found entry already at the largest count
    } t_scan_ctl;

endpackage

`default_nettype wire

// File: sv/stcl_if.sv
// Request and result channel interfaces (valid/ready handshake).
// Depends on stcl_pkg.
`default_nettype none

interface stcl_req_if;
    logic                         valid;
    logic                         ready;
    stcl_pkg::t_func              func;
    logic [stcl_pkg::WORD_W-1:0]  word_id;
    logic [stcl_pkg::TOPIC_W-1:0] topic_id;
    logic [stcl_pkg::SLOT_W-1:0]  slot_sel;

    modport source (output valid, func, word_id, topic_id, slot_sel, input ready);
    modport sink   (input valid, func, word_id, topic_id, slot_sel, output ready);
endinterface

interface stcl_res_if;
    logic                           valid;
    logic                           ready;
    logic [stcl_pkg::CNT_OUT_W-1:0] count_out;
    logic [stcl_pkg::TOPIC_W-1:0]   topic_out;
    logic [stcl_pkg::SLOT_W-1:0]    slot_out;
    stcl_pkg::t_status              status;

    modport source (output valid, count_out, topic_out, slot_out, status, input ready);
    modport sink   (input valid, count_out, topic_out, slot_out, status, output ready);
endinterface

`default_nettype wire

// File: sv/stcl_row_mem.sv
// Row store: one word's whole list per entry, one write and one registered read port.
// Depends on nothing but the parameters given by the top level.
`default_nettype none

module stcl_row_mem #(
    parameter int WORDS = 1024,
    parameter int ROW_W = 672
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_waddr,
    input  wire logic [ROW_W-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_raddr,
    output logic      [ROW_W-1:0]                     o_rdata
);
    logic [ROW_W-1:0] r_mem [WORDS];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/stcl_scan.sv
// Scan stage: finds the topic or the end of the live list in a row, registers the result.
// Depends on stcl_pkg.
`default_nettype none

module stcl_scan #(
    parameter int TOPICS     = 32,
    parameter int TOPIC_BITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_en,
    input  wire logic [TOPICS-1:0][COUNT_BITS+TOPIC_BITS-1:0] i_row,
    input  wire logic [stcl_pkg::TOPIC_W-1:0]              i_topic,
    output logic      [$clog2(TOPICS)-1:0]                 o_pos,
    output logic      [COUNT_BITS+TOPIC_BITS-1:0]          o_val,
    output stcl_pkg::t_scan_ctl                            o_ctl
);
    import stcl_pkg::*;

    localparam int SW = $clog2(TOPICS);
    localparam int VW = COUNT_BITS + TOPIC_BITS;

    logic [TOPICS-1:0] live;
    logic [TOPICS-1:0] hit;
    logic [SW-1:0]     pos_c;
    logic              found_c;
    logic              full_c;
    logic [VW-1:0]     val_c;

    logic [SW-1:0]     r_pos;
    logic [VW-1:0]     r_val;
    t_scan_ctl         r_ctl;

    always_comb begin
        for (int j = 0; j < TOPICS; j++) begin
            live[j] = |i_row[j][VW-1:TOPIC_BITS];
            hit[j]  = !live[j] || (i_row[j][TOPIC_BITS-1:0] == TOPIC_BITS'(i_topic));
        end
    end

    // lowest hit wins: a dead slot ends the list before any later match
    always_comb begin
        pos_c   = '0;
        found_c = 1'b0;
        full_c  = 1'b1;
        for (int j = TOPICS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                pos_c   = SW'(j);
                found_c = live[j];
                full_c  = 1'b0;
            end
        end
        val_c = i_row[pos_c];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos     <= pos_c;
            r_val     <= val_c;
            r_ctl.found <= found_c;
            r_ctl.full  <= full_c;
            r_ctl.sat   <= &val_c[VW-1:TOPIC_BITS];
        end
    end

    assign o_pos = r_pos;
    assign o_val = r_val;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// File: sv/stcl_update.sv
// Update stage: appends or adjusts an entry, moves it into place and forms the result.
// Depends on stcl_pkg.
`default_nettype none

module stcl_update #(
    parameter int TOPICS     = 32,
    parameter int TOPIC_BITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  wire logic [TOPICS-1:0][COUNT_BITS+TOPIC_BITS-1:0] i_row,
    input  wire logic [$clog2(TOPICS)-1:0]                 i_pos,
    input  wire logic [COUNT_BITS+TOPIC_BITS-1:0]          i_val,
    input  wire stcl_pkg::t_scan_ctl                       i_ctl,
    input  wire stcl_pkg::t_func                           i_func,
    input  wire logic [stcl_pkg::TOPIC_W-1:0]              i_topic,
    input  wire logic [stcl_pkg::SLOT_W-1:0]               i_sel,
    input  wire logic                                      i_word_oor,
    input  wire logic                                      i_topic_oor,
    output logic                                           o_we,
    output logic      [TOPICS-1:0][COUNT_BITS+TOPIC_BITS-1:0] o_row,
    output stcl_pkg::t_result                              o_res
);
    import stcl_pkg::*;

    localparam int SW = $clog2(TOPICS);
    localparam int VW = COUNT_BITS + TOPIC_BITS;

    logic [VW-1:0]                 one_cnt;
    logic [VW-1:0]                 v_inc;
    logic [VW-1:0]                 v_dec;
    logic [SW-1:0]                 pos_inc;
    logic [SW-1:0]                 pos_dec;
    logic [TOPICS-1:0][VW-1:0]     sh_up;     // sh_up[j] = row[j-1]
    logic [TOPICS-1:0][VW-1:0]     sh_dn;     // sh_dn[j] = row[j+1]
    logic [TOPICS-1:0][VW-1:0]     row_inc;
    logic [TOPICS-1:0][VW-1:0]     row_dec;
    logic [TOPICS-1:0][VW-1:0]     row_app;
    logic [SW-1:0]                 rd_idx;
    logic [VW-1:0]                 rd_val;

    assign one_cnt = VW'(1) << TOPIC_BITS;
    assign v_inc   = i_val + one_cnt;
    assign v_dec   = i_val - one_cnt;
    assign rd_idx  = SW'(i_sel);
    assign rd_val  = i_row[rd_idx];

    for (genvar g = 0; g < TOPICS; g++) begin : g_shift
        if (g == 0) begin : g_first
            assign sh_up[g] = i_row[g];
        end else begin : g_up
            assign sh_up[g] = i_row[g-1];
        end
        if (g == TOPICS - 1) begin : g_last
            assign sh_dn[g] = i_row[g];
        end else begin : g_dn
            assign sh_dn[g] = i_row[g+1];
        end
    end

    // Bubble toward slot 0 stops after the last left neighbour not below the new value;
    // bubble toward the end stops before the first right neighbour not above it.
    always_comb begin
        pos_inc = '0;
        for (int m = 0; m < TOPICS; m++) begin
            if ((SW'(m) < i_pos) && (i_row[m] >= v_inc)) begin
                pos_inc = SW'(m + 1);
            end
        end
        pos_dec = SW'(TOPICS - 1);
        for (int m = TOPICS - 1; m >= 0; m--) begin
            if ((SW'(m) > i_pos) && (i_row[m] <= v_dec)) begin
                pos_dec = SW'(m - 1);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < TOPICS; j++) begin
            if (SW'(j) == pos_inc) begin
                row_inc[j] = v_inc;
            end else if ((SW'(j) > pos_inc) && (SW'(j) <= i_pos)) begin
                row_inc[j] = sh_up[j];
            end else begin
                row_inc[j] = i_row[j];
            end

            if (SW'(j) == pos_dec) begin
                row_dec[j] = v_dec;
            end else if ((SW'(j) >= i_pos) && (SW'(j) < pos_dec)) begin
                row_dec[j] = sh_dn[j];
            end else begin
                row_dec[j] = i_row[j];
            end

            if (SW'(j) == i_pos) begin
                row_app[j] = {COUNT_BITS'(1), TOPIC_BITS'(i_topic)};
            end else begin
                row_app[j] = i_row[j];
            end
        end
    end

    always_comb begin
        o_we  = 1'b0;
        o_row = i_row;
        o_res = '{count_out: '0, topic_out: '0, slot_out: '0, status: STAT_OK};
        unique case (i_func)
            FN_NONE: begin
                o_res.status = STAT_OK;
            end
            FN_READ: begin
                if (i_word_oor) begin
                    o_res.status = STAT_RANGE;
                end else if (32'(i_sel) >= TOPICS) begin
                    o_res.slot_out = i_sel;
                    o_res.status   = STAT_RANGE;
                end else begin
                    o_res.count_out = CNT_OUT_W'(rd_val[VW-1:TOPIC_BITS]);
                    o_res.topic_out = TOPIC_W'(rd_val[TOPIC_BITS-1:0]);
                    o_res.slot_out  = i_sel;
                end
            end
            FN_INC, FN_DEC: begin
                if (i_word_oor) begin
                    o_res.status = STAT_RANGE;
                end else if (i_topic_oor) begin
                    o_res.topic_out = i_topic;
                    o_res.status    = STAT_RANGE;
                end else if (!i_ctl.found) begin
                    o_res.topic_out = i_topic;
                    if (i_func == FN_DEC) begin
                        o_res.status = STAT_ABSENT;
                    end else if (i_ctl.full) begin
                        o_res.status = STAT_RANGE;
                    end else begin
                        o_we            = 1'b1;
                        o_row           = row_app;
                        o_res.count_out = CNT_OUT_W'(1);
                        o_res.slot_out  = SLOT_W'(i_pos);
                    end
                end else if (i_func == FN_INC) begin
                    if (i_ctl.sat) begin
                        o_res.count_out = CNT_OUT_W'(i_val[VW-1:TOPIC_BITS]);
                        o_res.topic_out = TOPIC_W'(i_val[TOPIC_BITS-1:0]);
                        o_res.slot_out  = SLOT_W'(i_pos);
                        o_res.status    = STAT_SAT;
                    end else begin
                        o_we            = 1'b1;
                        o_row           = row_inc;
                        o_res.count_out = CNT_OUT_W'(v_inc[VW-1:TOPIC_BITS]);
                        o_res.topic_out = TOPIC_W'(v_inc[TOPIC_BITS-1:0]);
                        o_res.slot_out  = SLOT_W'(pos_inc);
                    end
                end else begin
                    o_we            = 1'b1;
                    o_row           = row_dec;
                    o_res.count_out = CNT_OUT_W'(v_dec[VW-1:TOPIC_BITS]);
                    o_res.topic_out = TOPIC_W'(v_dec[TOPIC_BITS-1:0]);
                    o_res.slot_out  = SLOT_W'(pos_dec);
                end
            end
            default: begin
                o_res.status = STAT_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sorted_topic_count_list_core.sv
// Sorted topic count lists, one row of TOPICS slots per word, held in one row memory.
// Steps: accept with row read in idle, registered scan, then update and write-back,
// where the result is registered. A new request is taken only after the return to
// idle, so requests do not overlap. A finished result waiting downstream holds the
// next write-back until it is taken.
// Reset: clears the row memory one row per cycle, with requests held off.
`default_nettype none

module sorted_topic_count_list_core #(
    parameter int WORDS      = 1024,
    parameter int TOPICS     = 32,
    parameter int TOPIC_BITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    stcl_req_if.sink                          i_req,
    stcl_res_if.source                        o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stcl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stcl_pkg::PDATA_W-1:0] pwdata,
    output logic      [stcl_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import stcl_pkg::*;

    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW    = $clog2(TOPICS);
    localparam int VW    = COUNT_BITS + TOPIC_BITS;
    localparam int ROW_W = TOPICS * VW;
    localparam logic [31:0] TLIM = (TOPICS < (2 ** TOPIC_BITS)) ? TOPICS : (2 ** TOPIC_BITS);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [TIU_W-1:0]    r_tiu;
    t_func               r_func;
    logic [WORD_W-1:0]   r_word;
    logic [TOPIC_W-1:0]  r_topic;
    logic [SLOT_W-1:0]   r_sel;
    t_result             r_res;
    logic                r_out_valid;

    logic                accept;
    logic                out_free;
    logic                commit;
    logic                word_oor;
    logic                topic_oor;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic [TOPICS-1:0][VW-1:0] rd_row;
    logic [SW-1:0]       scan_pos;
    logic [VW-1:0]       scan_val;
    t_scan_ctl           scan_ctl;
    logic                upd_we;
    logic [TOPICS-1:0][VW-1:0] upd_row;
    t_result             upd_res;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu <= TIU_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TIU)) begin
            r_tiu <= pwdata[TIU_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIU) ? PDATA_W'(r_tiu) : '0;

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign commit      = (r_state == S_WRITE) && out_free;

    assign word_oor  = 32'(r_word) >= WORDS;
    assign topic_oor = (32'(r_topic) >= 32'(r_tiu)) || (32'(r_topic) >= TLIM);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_word  <= i_req.word_id;
            r_topic <= i_req.topic_id;
            r_sel   <= i_req.slot_sel;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory write port: clearing sweep or row write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = commit && upd_we;
            mem_waddr = AW'(r_word);
            mem_wdata = upd_row;
        end
    end

    stcl_row_mem #(
        .WORDS (WORDS),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_req.word_id)),
        .o_rdata (rd_row)
    );

    stcl_scan #(
        .TOPICS     (TOPICS),
        .TOPIC_BITS (TOPIC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_en    (r_state == S_SCAN),
        .i_row   (rd_row),
        .i_topic (r_topic),
        .o_pos   (scan_pos),
        .o_val   (scan_val),
        .o_ctl   (scan_ctl)
    );

    stcl_update #(
        .TOPICS     (TOPICS),
        .TOPIC_BITS (TOPIC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_row       (rd_row),
        .i_pos       (scan_pos),
        .i_val       (scan_val),
        .i_ctl       (scan_ctl),
        .i_func      (r_func),
        .i_topic     (r_topic),
        .i_sel       (r_sel),
        .i_word_oor  (word_oor),
        .i_topic_oor (topic_oor),
        .o_we        (upd_we),
        .o_row       (upd_row),
        .o_res       (upd_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_res <= upd_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.count_out = r_res.count_out;
    assign o_res.topic_out = r_res.topic_out;
    assign o_res.slot_out  = r_res.slot_out;
    assign o_res.status    = r_res.status;

`ifndef SYNTH
    a_accept_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted request did not move to scan");

    a_scan_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_WRITE))
        else $error("scan not followed by write-back");

    a_no_write_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state != S_CLEAR))
            |-> (!word_oor && (r_func == FN_INC || r_func == FN_DEC)))
        else $error("row write for a request that must leave the store unchanged");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_WRITE))
        else $error("result appeared without a write-back step");
`endif

endmodule

`default_nettype wire

// File: dv/sorted_topic_count_list_checker.sv
// Scoreboard for the sorted topic count list core: watches request, result and APB traffic.
// Keeps its own copy of every word's list and of the topic limit, and compares each result.
// Depends on stcl_pkg and the channel interfaces in stcl_if.sv.
`default_nettype none

module sorted_topic_count_list_checker #(
    parameter int WORDS      = 1024,
    parameter int TOPICS     = 32,
    parameter int TOPIC_BITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    stcl_req_if                               i_req,
    stcl_res_if                               i_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic                         pready,
    input  wire logic [stcl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stcl_pkg::PDATA_W-1:0] pwdata,
    input  wire logic [stcl_pkg::PDATA_W-1:0] prdata,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_swaps,
    output int                                o_saturated,
    output int                                o_out_of_range,
    output int                                o_absent
);
    import stcl_pkg::*;

    localparam int                 ENTRY_W   = COUNT_BITS + TOPIC_BITS;
    localparam logic [PADDR_W-1:0] TIU_ADDR  = PADDR_W'({REG_TIU, 2'b00});
    localparam int                 MAX_PRINT = 100;

    typedef struct {
        t_result             res;
        int unsigned         seq;
        t_func               fn;
        logic [WORD_W-1:0]   word;
        logic [TOPIC_W-1:0]  topic;
        logic [SLOT_W-1:0]   sel;
    } t_slot_outcome;

    // packed {count, topic} per slot, row-major by word
    logic [ENTRY_W-1:0] count_list [WORDS*TOPICS];
    logic [TIU_W-1:0]   topic_limit;
    t_slot_outcome      outcome_q [$];
    int unsigned        req_seq;
    int                 fail_cnt, result_cnt, swap_cnt, sat_cnt, range_cnt, absent_cnt;

    assign o_fail_count   = fail_cnt;
    assign o_results      = result_cnt;
    assign o_swaps        = swap_cnt;
    assign o_saturated    = sat_cnt;
    assign o_out_of_range = range_cnt;
    assign o_absent       = absent_cnt;

    initial begin
        fail_cnt   = 0;
        result_cnt = 0;
        swap_cnt   = 0;
        sat_cnt    = 0;
        range_cnt  = 0;
        absent_cnt = 0;
        req_seq    = 0;
        o_pending  = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        // keep the log bounded if the block is badly broken
        if (fail_cnt <= MAX_PRINT)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic string describe(input t_slot_outcome o);
        return $sformatf("request %0d (%s word %0d topic %0d slot %0d)",
                         o.seq, o.fn.name(), o.word, o.topic, o.sel);
    endfunction

    function automatic t_result apply_list_update(input t_func fn,
                                                  input logic [WORD_W-1:0] word,
                                                  input logic [TOPIC_W-1:0] topic,
                                                  input logic [SLOT_W-1:0] sel);
        t_result            r;
        int unsigned        base, lim, p;
        bit                 found;
        logic [ENTRY_W-1:0] tmp;
        r     = '0;
        found = 1'b0;
        if (fn == FN_NONE)
            return r;
        if (word >= WORDS) begin
            r.status = STAT_RANGE;
            return r;
        end
        base = word * TOPICS;
        if (fn == FN_READ) begin
            r.slot_out = sel;
            if (sel >= TOPICS) begin
                r.status = STAT_RANGE;
                return r;
            end
            tmp         = count_list[base + sel];
            r.count_out = CNT_OUT_W'(tmp[ENTRY_W-1:TOPIC_BITS]);
            r.topic_out = TOPIC_W'(tmp[TOPIC_BITS-1:0]);
            r.status    = STAT_OK;
            return r;
        end
        lim = topic_limit;
        if (lim > TOPICS)
            lim = TOPICS;
        if (lim > 2**TOPIC_BITS)
            lim = 2**TOPIC_BITS;
        if (topic >= lim) begin
            r.topic_out = topic;
            r.status    = STAT_RANGE;
            return r;
        end
        // scan stops at the first empty slot or at the matching topic
        for (p = 0; p < TOPICS; p++) begin
            tmp = count_list[base + p];
            if (tmp[ENTRY_W-1:TOPIC_BITS] == '0)
                break;
            if (tmp[TOPIC_BITS-1:0] == topic) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            r.topic_out = topic;
            if (fn == FN_DEC) begin
                r.status = STAT_ABSENT;
            end else if (p >= TOPICS) begin
                r.status = STAT_RANGE;
            end else begin
                count_list[base + p] = {COUNT_BITS'(1), TOPIC_BITS'(topic)};
                r.count_out = CNT_OUT_W'(1);
                r.slot_out  = SLOT_W'(p);
                r.status    = STAT_OK;
            end
            return r;
        end
        tmp = count_list[base + p];
        if (fn == FN_INC) begin
            if (tmp[ENTRY_W-1:TOPIC_BITS] == {COUNT_BITS{1'b1}}) begin
                r.count_out = CNT_OUT_W'(tmp[ENTRY_W-1:TOPIC_BITS]);
                r.topic_out = TOPIC_W'(tmp[TOPIC_BITS-1:0]);
                r.slot_out  = SLOT_W'(p);
                r.status    = STAT_SAT;
                return r;
            end
            count_list[base + p] = tmp + (ENTRY_W'(1) << TOPIC_BITS);
            while (p > 0 && count_list[base + p] > count_list[base + p - 1]) begin
                tmp                      = count_list[base + p];
                count_list[base + p]     = count_list[base + p - 1];
                count_list[base + p - 1] = tmp;
                p--;
                swap_cnt++;
            end
        end else begin
            count_list[base + p] = tmp - (ENTRY_W'(1) << TOPIC_BITS);
            // a decrement sinks past live entries and also past stale topics
            while (p + 1 < TOPICS && count_list[base + p] < count_list[base + p + 1]) begin
                tmp                      = count_list[base + p];
                count_list[base + p]     = count_list[base + p + 1];
                count_list[base + p + 1] = tmp;
                p++;
                swap_cnt++;
            end
        end
        tmp         = count_list[base + p];
        r.count_out = CNT_OUT_W'(tmp[ENTRY_W-1:TOPIC_BITS]);
        r.topic_out = TOPIC_W'(tmp[TOPIC_BITS-1:0]);
        r.slot_out  = SLOT_W'(p);
        r.status    = STAT_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_outcome o;
        if (!i_rst_n) begin
            foreach (count_list[k])
                count_list[k] = '0;
            topic_limit = TIU_RESET;
            outcome_q.delete();
        end else begin
            if (psel && penable && pready && paddr == TIU_ADDR) begin
                if (pwrite)
                    topic_limit = pwdata[TIU_W-1:0];
                else if (prdata !== PDATA_W'(topic_limit))
                    report_mismatch($sformatf("topics_in_use read back %0d, predicted %0d",
                                              prdata, topic_limit));
            end
            // results first: a request taken at this edge cannot be answered at it
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                result_cnt++;
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: count %0d topic %0d slot %0d status %0d",
                        i_res.count_out, i_res.topic_out, i_res.slot_out, i_res.status));
                end else begin
                    o = outcome_q.pop_front();
                    if (i_res.count_out !== o.res.count_out)
                        report_mismatch($sformatf("%s: count_out %0d, predicted %0d",
                                                  describe(o), i_res.count_out, o.res.count_out));
                    if (i_res.topic_out !== o.res.topic_out)
                        report_mismatch($sformatf("%s: topic_out %0d, predicted %0d",
                                                  describe(o), i_res.topic_out, o.res.topic_out));
                    if (i_res.slot_out !== o.res.slot_out)
                        report_mismatch($sformatf("%s: slot_out %0d, predicted %0d",
                                                  describe(o), i_res.slot_out, o.res.slot_out));
                    if (i_res.status !== o.res.status)
                        report_mismatch($sformatf("%s: status %0d, predicted %s",
                                                  describe(o), i_res.status, o.res.status.name()));
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                o.seq   = req_seq++;
                o.fn    = i_req.func;
                o.word  = i_req.word_id;
                o.topic = i_req.topic_id;
                o.sel   = i_req.slot_sel;
                o.res   = apply_list_update(o.fn, o.word, o.topic, o.sel);
                case (o.res.status)
                    STAT_SAT:    sat_cnt++;
                    STAT_RANGE:  range_cnt++;
                    STAT_ABSENT: absent_cnt++;
                    default: ;
                endcase
                outcome_q = {outcome_q, o};
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

`default_nettype wire

// File: dv/sorted_topic_count_list_core_tb.sv
// Top of the sorted topic count list testbench: clock, reset, request and APB stimulus.
// Instantiates the core and sorted_topic_count_list_checker; depends on stcl_pkg and stcl_if.sv.
`default_nettype none

module sorted_topic_count_list_core_tb;
    import stcl_pkg::*;

    localparam int WORDS           = 1024;
    localparam int TOPICS          = 32;
    localparam int TOPIC_BITS      = 5;
    localparam int COUNT_BITS      = 16;
    localparam int MAX_GAP         = 13;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 7;
    localparam int PHASE_ITEMS     = 285;
    localparam int BURST_ITEMS     = 20;
    localparam int SAT_WORD        = 1022;
    localparam logic [PADDR_W-1:0] TIU_ADDR = PADDR_W'({REG_TIU, 2'b00});

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bit                 tx_idle;
    bit                 rx_idle;
    bit                 hold_off_req;
    logic [TIU_W-1:0]   cur_tiu;

    int chk_fail, chk_pending, chk_results, chk_swaps, chk_sat, chk_range, chk_absent;

    stcl_req_if req_ch ();
    stcl_res_if res_ch ();

    sorted_topic_count_list_core #(
        .WORDS      (WORDS),
        .TOPICS     (TOPICS),
        .TOPIC_BITS (TOPIC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sorted_topic_count_list_checker #(
        .WORDS      (WORDS),
        .TOPICS     (TOPICS),
        .TOPIC_BITS (TOPIC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_res          (res_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .o_fail_count   (chk_fail),
        .o_pending      (chk_pending),
        .o_results      (chk_results),
        .o_swaps        (chk_swaps),
        .o_saturated    (chk_sat),
        .o_out_of_range (chk_range),
        .o_absent       (chk_absent)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one request, after a random gap when tx_idle is set, and hold it until taken.
    task automatic send_request(input t_func fn, input logic [WORD_W-1:0] word,
                                input logic [TOPIC_W-1:0] topic, input logic [SLOT_W-1:0] sel);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= fn;
        req_ch.word_id  <= word;
        req_ch.topic_id <= topic;
        req_ch.slot_sel <= sel;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait until every outstanding request has been answered.
    task automatic drain;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_topic_limit(input logic [TIU_W-1:0] value);
        drain();
        apb_access(1'b1, TIU_ADDR, PDATA_W'(value));
        apb_access(1'b0, TIU_ADDR, '0);
        cur_tiu = value;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    initial begin
        logic [TIU_W-1:0]   phase_tiu [PHASES];
        logic [WORD_W-1:0]  hot_words [4];
        logic [WORD_W-1:0]  w;
        logic [TOPIC_W-1:0] t;
        t_func              fn;
        int unsigned        lim, pick, items;

        req_ch.valid    = 1'b0;
        req_ch.func     = FN_INC;
        req_ch.word_id  = '0;
        req_ch.topic_id = '0;
        req_ch.slot_sel = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        hold_off_req    = 1'b0;
        cur_tiu         = TIU_RESET;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the limit, then an explicit write of the widest setting
        apb_access(1'b0, TIU_ADDR, '0);
        set_topic_limit(6'd32);

        // empty lists, absent decrement, appends, moves up and sinking to zero
        send_request(FN_READ, 10'd0,    5'd0,  5'd0);
        send_request(FN_READ, 10'd1023, 5'd31, 5'd31);
        send_request(FN_DEC,  10'd0,    5'd3,  5'd0);
        send_request(FN_INC,  10'd0,    5'd3,  5'd0);
        send_request(FN_INC,  10'd0,    5'd7,  5'd0);
        send_request(FN_INC,  10'd0,    5'd7,  5'd0);
        send_request(FN_INC,  10'd0,    5'd31, 5'd0);
        send_request(FN_INC,  10'd0,    5'd0,  5'd0);
        send_request(FN_INC,  10'd0,    5'd31, 5'd0);
        send_request(FN_DEC,  10'd0,    5'd7,  5'd0);
        send_request(FN_DEC,  10'd0,    5'd7,  5'd0);
        send_request(FN_READ, 10'd0,    5'd3,  5'd3);
        send_request(FN_READ, 10'd0,    5'd0,  5'd4);
        send_request(FN_NONE, 10'd1023, 5'd31, 5'd31);
        send_request(FN_INC,  10'd1023, 5'd31, 5'd0);

        // limit of one: topic 1 and above are out of range
        set_topic_limit(6'd1);
        send_request(FN_INC,  10'd5, 5'd1,  5'd0);
        send_request(FN_INC,  10'd5, 5'd0,  5'd0);
        send_request(FN_DEC,  10'd5, 5'd31, 5'd0);
        send_request(FN_READ, 10'd5, 5'd0,  5'd0);
        send_request(FN_DEC,  10'd5, 5'd0,  5'd0);
        send_request(FN_DEC,  10'd5, 5'd0,  5'd0);

        // back-to-back increments on one word with no stalls
        set_topic_limit(6'd32);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < BURST_ITEMS; n++)
            send_request(FN_INC, WORD_W'(SAT_WORD), 5'd31, 5'd0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(FN_INC,  WORD_W'(SAT_WORD), 5'd31, 5'd0);
        send_request(FN_INC,  WORD_W'(SAT_WORD), 5'd0,  5'd0);
        send_request(FN_INC,  WORD_W'(SAT_WORD), 5'd0,  5'd0);
        send_request(FN_DEC,  WORD_W'(SAT_WORD), 5'd31, 5'd0);
        send_request(FN_INC,  WORD_W'(SAT_WORD), 5'd31, 5'd0);
        send_request(FN_INC,  WORD_W'(SAT_WORD), 5'd31, 5'd0);
        send_request(FN_READ, WORD_W'(SAT_WORD), 5'd0,  5'd0);

        // random phases; a few hot words so the lists grow long and reorder often
        phase_tiu = '{6'd32, 6'd1, 6'd9, 6'd63, 6'd0, 6'd24,
                      TIU_W'($urandom_range(1, TOPICS))};
        hot_words[0] = WORD_W'($urandom);
        hot_words[1] = WORD_W'($urandom);
        for (int ph = 0; ph < PHASES; ph++) begin
            set_topic_limit(phase_tiu[ph]);
            hot_words[2] = WORD_W'($urandom);
            hot_words[3] = WORD_W'($urandom);
            lim   = (cur_tiu > TOPICS) ? TOPICS : cur_tiu;
            items = (cur_tiu == 0) ? 40 : PHASE_ITEMS;
            for (int n = 0; n < items; n++) begin
                if (n % 64 == 0) begin
                    tx_idle = ($urandom_range(0, 3) != 0);
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                // long receiver hold-off while requests keep coming back to back
                if (ph == 0 && n == 100)
                    hold_off_req = 1'b1;
                if (ph == 0 && n >= 100 && n < 130)
                    tx_idle = 1'b0;
                pick = $urandom_range(0, 99);
                fn = (pick < 55) ? FN_INC : (pick < 85) ? FN_DEC :
                     (pick < 97) ? FN_READ : FN_NONE;
                w = ($urandom_range(0, 6) != 0) ? hot_words[$urandom_range(0, 3)]
                                                : WORD_W'($urandom);
                t = (lim > 0 && $urandom_range(0, 7) != 0) ? TOPIC_W'($urandom_range(0, lim - 1))
                                                           : TOPIC_W'($urandom);
                send_request(fn, w, t, SLOT_W'($urandom));
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d results with %0d reorder swaps, %0d saturated increments,",
                 chk_results, chk_swaps, chk_sat);
        $display("%0d out-of-range and %0d absent decrements, over seven topic limits.",
                 chk_range, chk_absent);
        if (chk_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
